// ----- hw/rtl/rgb_to_two_pwm_channel_mapper_core_defines.svh -----
// assertion macros for the rgb to two pwm channel mapper
`ifndef RGB_TO_TWO_PWM_CHANNEL_MAPPER_CORE_DEFINES_SVH
`define RGB_TO_TWO_PWM_CHANNEL_MAPPER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define RTPM_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rtpm same-cycle check failed");

// implication checked in the cycle after the antecedent
`define RTPM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rtpm next-cycle check failed");

`endif

// ----- hw/rtl/rtpm_pkg.sv -----
// shared types and constants for the rgb to two pwm channel mapper
package rtpm_pkg;

   typedef logic [7:0] level_type;
   typedef logic [1:0] mode_type;

   localparam mode_type MODE_OFF = 2'd0;
   localparam mode_type MODE_ON  = 2'd1;
   localparam mode_type MODE_CH0 = 2'd2;
   localparam mode_type MODE_CH1 = 2'd3;

   localparam level_type LEVEL_OFF  = 8'd0;
   localparam level_type LEVEL_FULL = 8'd255;

   typedef struct packed {
      level_type duty_a;
      level_type duty_b;
      mode_type  green_mode;
      mode_type  red_mode;
      mode_type  blue_mode;
   } rtpm_result_type;

endpackage

// ----- hw/rtl/rgb_to_two_pwm_channel_mapper_core.sv -----
// top level of the rgb to two pwm channel mapper
// A request is a transfer at a rising edge with start high; busy is always low, so a new
// request can be taken every cycle. Each request gives one result: its levels are
// captured in an input register, mapped by short combinational logic, and
// held in a result register. rsp_valid marks the result for exactly one cycle and the
// receiver cannot stall, so the result must be taken in that cycle.
`include "rgb_to_two_pwm_channel_mapper_core_defines.svh"
module rgb_to_two_pwm_channel_mapper_core import rtpm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   output logic      busy,
   input  level_type req_red_level,
   input  level_type req_green_level,
   input  level_type req_blue_level,
   output logic      rsp_valid,
   output level_type rsp_duty_a,
   output level_type rsp_duty_b,
   output mode_type  rsp_green_mode,
   output mode_type  rsp_red_mode,
   output mode_type  rsp_blue_mode
);

   logic            stage_valid_ff;
   logic            stage_valid_in;
   level_type       red_ff;
   level_type       green_ff;
   level_type       blue_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rtpm_result_type result_ff;
   rtpm_result_type result_in;
   logic            ch1_unused;

   assign busy           = 1'b0;
   assign stage_valid_in = start & ~busy;
   assign rsp_valid_in   = stage_valid_ff;

   rtpm_map u_map (
      .red_level   (red_ff),
      .green_level (green_ff),
      .blue_level  (blue_ff),
      .result      (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_valid_in) begin
         red_ff   <= req_red_level;
         green_ff <= req_green_level;
         blue_ff  <= req_blue_level;
      end
      if (rsp_valid_in) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_duty_a     = result_ff.duty_a;
   assign rsp_duty_b     = result_ff.duty_b;
   assign rsp_green_mode = result_ff.green_mode;
   assign rsp_red_mode   = result_ff.red_mode;
   assign rsp_blue_mode  = result_ff.blue_mode;

   assign ch1_unused = (rsp_green_mode != MODE_CH1) && (rsp_red_mode != MODE_CH1)
                       && (rsp_blue_mode != MODE_CH1);

   `RTPM_ASSERT_NEXT(a_req_reaches_rsp, start && !busy, ##1 rsp_valid)
   `RTPM_ASSERT_IMPL(a_rsp_has_req, rsp_valid, $past(start, 2))
   `RTPM_ASSERT_IMPL(a_green_never_ch1, rsp_valid, rsp_green_mode != MODE_CH1)
   `RTPM_ASSERT_IMPL(a_unused_ch1_zero, rsp_valid && ch1_unused, rsp_duty_b == LEVEL_OFF)

endmodule

// ----- hw/rtl/rtpm_map.sv -----
// combinational mapping of one color request onto two pwm channels
module rtpm_map import rtpm_pkg::*; (
   input  level_type       red_level,
   input  level_type       green_level,
   input  level_type       blue_level,
   output rtpm_result_type result
);

   level_type ch0_g;
   level_type ch0_r;
   level_type ch1_r;
   level_type d_gb;
   level_type d_gr;
   level_type d_br;
   logic [8:0] sum_gb;
   logic [8:0] sum_rb;
   logic [8:0] sum_gr;

   assign d_gb = (green_level > blue_level) ? green_level - blue_level
                                            : blue_level - green_level;
   assign d_gr = (green_level > red_level) ? green_level - red_level
                                           : red_level - green_level;
   assign d_br = (blue_level > red_level) ? blue_level - red_level
                                          : red_level - blue_level;

   assign sum_gb = {1'b0, green_level} + {1'b0, blue_level};
   assign sum_rb = {1'b0, red_level} + {1'b0, blue_level};
   assign sum_gr = {1'b0, green_level} + {1'b0, red_level};

   always_comb begin
      result = '0;
      ch0_g  = LEVEL_OFF;
      ch0_r  = LEVEL_OFF;
      ch1_r  = LEVEL_OFF;

      // green
      if (green_level == LEVEL_OFF) begin
         result.green_mode = MODE_OFF;
      end else if (green_level == LEVEL_FULL) begin
         result.green_mode = MODE_ON;
      end else begin
         ch0_g             = green_level;
         result.green_mode = MODE_CH0;
      end

      // red
      ch0_r = ch0_g;
      if (red_level == LEVEL_OFF) begin
         result.red_mode = MODE_OFF;
      end else if (red_level == LEVEL_FULL) begin
         result.red_mode = MODE_ON;
      end else if ((ch0_g == LEVEL_OFF) || (ch0_g == red_level)) begin
         ch0_r           = red_level;
         result.red_mode = MODE_CH0;
      end else begin
         ch1_r           = red_level;
         result.red_mode = MODE_CH1;
      end

      // blue
      result.duty_a = ch0_r;
      result.duty_b = ch1_r;
      if (blue_level == LEVEL_OFF) begin
         result.blue_mode = MODE_OFF;
      end else if (blue_level == LEVEL_FULL) begin
         result.blue_mode = MODE_ON;
      end else if ((ch0_r == LEVEL_OFF) || (ch0_r == blue_level)) begin
         result.duty_a    = blue_level;
         result.blue_mode = MODE_CH0;
      end else if ((ch1_r == LEVEL_OFF) || (ch1_r == blue_level)) begin
         result.duty_b    = blue_level;
         result.blue_mode = MODE_CH1;
      end else if ((d_gb < d_gr) && (d_gb < d_br)) begin
         // three-way conflict: blue closest to green
         result.blue_mode = MODE_CH0;
         result.duty_a    = sum_gb[8:1];
      end else if ((d_br <= d_gr) && (d_br <= d_gb)) begin
         // blue closest to red
         result.blue_mode = MODE_CH1;
         result.duty_b    = sum_rb[8:1];
      end else begin
         // red joins green, blue alone
         result.red_mode  = MODE_CH0;
         result.duty_a    = sum_gr[8:1];
         result.blue_mode = MODE_CH1;
         result.duty_b    = blue_level;
      end
   end

endmodule
